FILE: design/bcd_pkg.sv
// ----------------------------------------------------------------------------
// bcd_pkg: shared types, constants and helpers for the BC1/BC2/BC3 decoder
// Field widths, register and format codes, palette types, RGB565 widening and
// reciprocal-multiply divisions by 3, 5 and 7.
// ----------------------------------------------------------------------------
package bcd_pkg;

	localparam int unsigned ALPHA_HALF_W = 64;
	localparam int unsigned COLOR_HALF_W = 64;
	localparam int unsigned BLOCK_POS_W  = 11;
	localparam int unsigned TEXEL_POS_W  = BLOCK_POS_W + 2;
	localparam int unsigned CHAN_W       = 8;
	localparam int unsigned SEL_W        = 32;
	localparam int unsigned DIM_W        = 14;
	localparam int unsigned CFG_INDEX_W  = 2;
	localparam int unsigned CFG_DATA_W   = 14;
	localparam int unsigned TEXEL_CNT_W  = 4;

	localparam int unsigned DEFAULT_MAX_DIMENSION = 8192;
	localparam logic [DIM_W-1:0] DIM_RESET = 14'd8192;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

	// floor(v/3) = (v*683)>>11 for v < 2048
	localparam logic [11:0] RECIP3 = 12'd683;
	// floor(v/5) = (v*1639)>>13 for v < 2730
	localparam logic [10:0] RECIP5 = 11'd1639;
	// floor(v/7) = (v*2341)>>14 for v < 5461
	localparam logic [11:0] RECIP7 = 12'd2341;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TEXTURE_FORMAT = 2'd0,
		REG_IMAGE_WIDTH    = 2'd1,
		REG_IMAGE_HEIGHT   = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FMT_DXT1 = 2'd0,
		FMT_DXT3 = 2'd1,
		FMT_DXT5 = 2'd2
	} fmt_t;

	typedef logic [CHAN_W-1:0] chan_t;

	// index 0 red, 1 green, 2 blue
	typedef chan_t [2:0] rgb_t;

	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
		chan_t a;
	} rgba_t;

	typedef struct packed {
		logic [ALPHA_HALF_W-1:0] alpha_half;
		logic [COLOR_HALF_W-1:0] color_half;
		logic [BLOCK_POS_W-1:0]  block_col;
		logic [BLOCK_POS_W-1:0]  block_row;
	} block_t;

	typedef struct packed {
		rgba_t [3:0]             color;
		chan_t [7:0]             apal;
		logic [ALPHA_HALF_W-1:0] alpha_half;
		logic [SEL_W-1:0]        sel;
		logic [BLOCK_POS_W-1:0]  block_col;
		logic [BLOCK_POS_W-1:0]  block_row;
		fmt_t                    fmt;
	} pal_t;

	function automatic rgb_t expand565(input logic [15:0] v);
		rgb_t c;
		c[0] = {v[15:11], v[15:13]};
		c[1] = {v[10:5], v[10:9]};
		c[2] = {v[4:0], v[4:2]};
		return c;
	endfunction

	function automatic chan_t div3(input logic [9:0] v);
		logic [21:0] p;
		p = 22'(v) * 22'(RECIP3);
		return p[18:11];
	endfunction

	function automatic chan_t div5(input logic [10:0] v);
		logic [21:0] p;
		p = 22'(v) * 22'(RECIP5);
		return p[20:13];
	endfunction

	function automatic chan_t div7(input logic [10:0] v);
		logic [22:0] p;
		p = 23'(v) * 23'(RECIP7);
		return p[21:14];
	endfunction

endpackage

FILE: design/bcd_block_if.sv
// ----------------------------------------------------------------------------
// bcd_block_if: compressed block channel
// One item is one 4x4 block with its block column and row.
// ----------------------------------------------------------------------------
interface bcd_block_if;
	import bcd_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [ALPHA_HALF_W-1:0] alpha_half;
	logic [COLOR_HALF_W-1:0] color_half;
	logic [BLOCK_POS_W-1:0]  block_col;
	logic [BLOCK_POS_W-1:0]  block_row;

	modport source (output valid, alpha_half, color_half, block_col, block_row,
		input ready);
	modport sink (input valid, alpha_half, color_half, block_col, block_row,
		output ready);
endinterface

FILE: design/bcd_texel_if.sv
// ----------------------------------------------------------------------------
// bcd_texel_if: decoded texel channel
// One item is one RGBA8 texel with its image coordinates and flags.
// ----------------------------------------------------------------------------
interface bcd_texel_if;
	import bcd_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [TEXEL_POS_W-1:0] texel_x;
	logic [TEXEL_POS_W-1:0] texel_y;
	logic [CHAN_W-1:0]      red;
	logic [CHAN_W-1:0]      green;
	logic [CHAN_W-1:0]      blue;
	logic [CHAN_W-1:0]      alpha;
	logic                   inside_image;
	logic                   last_texel;

	modport source (output valid, texel_x, texel_y, red, green, blue, alpha,
		inside_image, last_texel, input ready);
	modport sink (input valid, texel_x, texel_y, red, green, blue, alpha,
		inside_image, last_texel, output ready);
endinterface

FILE: design/bcd_palette.sv
// ----------------------------------------------------------------------------
// bcd_palette: three-stage color and alpha palette builder
// Stage 1 captures the block, stage 2 widens endpoints and forms weighted
// sums, stage 3 divides by reciprocal multiply; the palette leaves selected.
// ----------------------------------------------------------------------------
module bcd_palette (
	input  logic             clk,
	input  logic             arst_n,
	input  bcd_pkg::fmt_t    texture_format,
	bcd_block_if.sink        blocks,
	output bcd_pkg::pal_t    pal,
	output logic             pal_valid,
	input  logic             pal_ready
);
	import bcd_pkg::*;

	// stage 1
	logic   v_s1;
	block_t blk_s1;
	fmt_t   fmt_s1;

	// stage 2
	logic                    v_s2;
	rgb_t                    e0_s2, e1_s2;
	logic [2:0][9:0]         sum_a_s2, sum_b_s2;
	logic                    four_s2, agt_s2;
	chan_t                   a0_s2, a1_s2;
	logic [5:0][10:0]        a7_s2;
	logic [3:0][10:0]        a5_s2;
	logic [ALPHA_HALF_W-1:0] alpha_half_s2;
	logic [SEL_W-1:0]        sel_s2;
	logic [BLOCK_POS_W-1:0]  col_s2, row_s2;
	fmt_t                    fmt_s2;

	// stage 3
	logic                    v_s3;
	rgb_t                    e0_s3, e1_s3;
	logic [2:0][7:0]         q3a_s3, q3b_s3, half_s3;
	logic                    four_s3, agt_s3;
	chan_t                   a0_s3, a1_s3;
	logic [5:0][7:0]         q7_s3;
	logic [3:0][7:0]         q5_s3;
	logic [ALPHA_HALF_W-1:0] alpha_half_s3;
	logic [SEL_W-1:0]        sel_s3;
	logic [BLOCK_POS_W-1:0]  col_s3, row_s3;
	fmt_t                    fmt_s3;

	logic rdy_s1, rdy_s2, rdy_s3;

	// stage 2 inputs
	rgb_t             e0_c, e1_c;
	logic [2:0][9:0]  sum_a_c, sum_b_c;
	chan_t            a0_c, a1_c;
	logic [5:0][10:0] a7_c;
	logic [3:0][10:0] a5_c;

	// stage 3 inputs
	logic [2:0][7:0] q3a_c, q3b_c, half_c;
	logic [5:0][7:0] q7_c;
	logic [3:0][7:0] q5_c;
	logic [2:0][8:0] pair_c;

	assign rdy_s3 = !v_s3 || pal_ready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign blocks.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= blocks.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_comb begin
		e0_c = expand565(blk_s1.color_half[15:0]);
		e1_c = expand565(blk_s1.color_half[31:16]);
		for (int k = 0; k < 3; k++) begin
			sum_a_c[k] = {1'b0, e0_c[k], 1'b0} + 10'(e1_c[k]);
			sum_b_c[k] = 10'(e0_c[k]) + {1'b0, e1_c[k], 1'b0};
		end
		a0_c = blk_s1.alpha_half[7:0];
		a1_c = blk_s1.alpha_half[15:8];
		for (int i = 1; i <= 6; i++) begin
			a7_c[i-1] = 11'((7 - i) * a0_c + i * a1_c);
		end
		for (int i = 1; i <= 4; i++) begin
			a5_c[i-1] = 11'((5 - i) * a0_c + i * a1_c);
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			q3a_c[k]  = div3(sum_a_s2[k]);
			q3b_c[k]  = div3(sum_b_s2[k]);
			pair_c[k] = 9'(e0_s2[k]) + 9'(e1_s2[k]);
			half_c[k] = pair_c[k][8:1];
		end
		for (int i = 0; i < 6; i++) begin
			q7_c[i] = div7(a7_s2[i]);
		end
		for (int i = 0; i < 4; i++) begin
			q5_c[i] = div5(a5_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && blocks.valid) begin
			blk_s1.alpha_half <= blocks.alpha_half;
			blk_s1.color_half <= blocks.color_half;
			blk_s1.block_col  <= blocks.block_col;
			blk_s1.block_row  <= blocks.block_row;
			fmt_s1            <= texture_format;
		end
		if (rdy_s2 && v_s1) begin
			e0_s2         <= e0_c;
			e1_s2         <= e1_c;
			sum_a_s2      <= sum_a_c;
			sum_b_s2      <= sum_b_c;
			four_s2       <= (fmt_s1 != FMT_DXT1) ||
				(blk_s1.color_half[15:0] > blk_s1.color_half[31:16]);
			agt_s2        <= a0_c > a1_c;
			a0_s2         <= a0_c;
			a1_s2         <= a1_c;
			a7_s2         <= a7_c;
			a5_s2         <= a5_c;
			alpha_half_s2 <= blk_s1.alpha_half;
			sel_s2        <= blk_s1.color_half[63:32];
			col_s2        <= blk_s1.block_col;
			row_s2        <= blk_s1.block_row;
			fmt_s2        <= fmt_s1;
		end
		if (rdy_s3 && v_s2) begin
			e0_s3         <= e0_s2;
			e1_s3         <= e1_s2;
			q3a_s3        <= q3a_c;
			q3b_s3        <= q3b_c;
			half_s3       <= half_c;
			four_s3       <= four_s2;
			agt_s3        <= agt_s2;
			a0_s3         <= a0_s2;
			a1_s3         <= a1_s2;
			q7_s3         <= q7_c;
			q5_s3         <= q5_c;
			alpha_half_s3 <= alpha_half_s2;
			sel_s3        <= sel_s2;
			col_s3        <= col_s2;
			row_s3        <= row_s2;
			fmt_s3        <= fmt_s2;
		end
	end

	// select final palettes
	always_comb begin
		pal.color[0] = '{r: e0_s3[0], g: e0_s3[1], b: e0_s3[2], a: CHAN_MAX};
		pal.color[1] = '{r: e1_s3[0], g: e1_s3[1], b: e1_s3[2], a: CHAN_MAX};
		if (four_s3) begin
			pal.color[2] = '{r: q3a_s3[0], g: q3a_s3[1], b: q3a_s3[2], a: CHAN_MAX};
			pal.color[3] = '{r: q3b_s3[0], g: q3b_s3[1], b: q3b_s3[2], a: CHAN_MAX};
		end else begin
			pal.color[2] = '{r: half_s3[0], g: half_s3[1], b: half_s3[2], a: CHAN_MAX};
			pal.color[3] = '0;
		end
		pal.apal[0] = a0_s3;
		pal.apal[1] = a1_s3;
		if (agt_s3) begin
			for (int i = 0; i < 6; i++) pal.apal[i+2] = q7_s3[i];
		end else begin
			for (int i = 0; i < 4; i++) pal.apal[i+2] = q5_s3[i];
			pal.apal[6] = '0;
			pal.apal[7] = CHAN_MAX;
		end
		pal.alpha_half = alpha_half_s3;
		pal.sel        = sel_s3;
		pal.block_col  = col_s3;
		pal.block_row  = row_s3;
		pal.fmt        = fmt_s3;
	end

	assign pal_valid = v_s3;

endmodule

FILE: design/bc1_bc2_bc3_block_decoder.sv
// ----------------------------------------------------------------------------
// bc1_bc2_bc3_block_decoder: DXT1/DXT3/DXT5 4x4 block decoder
// Builds the block palettes in a three-stage pipeline, then a serializer
// emits the sixteen texels in row order through a registered output stage.
// ----------------------------------------------------------------------------
// A block passes through the three palette stages, the serializer and the
// output register before its first texel is valid. The serializer, which sets
// the block rate, emits one texel per cycle while the sink is ready; the next
// block waits in the palette pipeline.
// Reset: clears all valid bits and the serializer; registers return to DXT1,
// width 8192, height 8192.
module bc1_bc2_bc3_block_decoder #(
	parameter int unsigned MAX_DIMENSION = bcd_pkg::DEFAULT_MAX_DIMENSION
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [bcd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bcd_pkg::CFG_DATA_W-1:0]  cfg_data,
	bcd_block_if.sink                      blocks,
	bcd_texel_if.source                    texels
);
	import bcd_pkg::*;

	localparam int unsigned LIM_W = ($clog2(MAX_DIMENSION + 1) > DIM_W) ?
		$clog2(MAX_DIMENSION + 1) : DIM_W;

	fmt_t             texture_format_q;
	logic [DIM_W-1:0] image_width_q, image_height_q;

	pal_t pal;
	logic pal_valid, pal_ready;

	// serializer
	logic                   v_s4;
	pal_t                   pal_s4;
	logic [TEXEL_CNT_W-1:0] cnt_q;
	logic                   s4_emit, s4_done;

	// output stage
	logic                   v_s5;
	logic [TEXEL_POS_W-1:0] texel_x_s5, texel_y_s5;
	rgba_t                  rgba_s5;
	logic                   inside_s5, last_s5;
	logic                   rdy_s5;

	logic [1:0]             ci;
	rgba_t                  col_c;
	logic [3:0]             nib;
	logic [5:0]             apos;
	logic [2:0]             aidx;
	chan_t                  alpha_c;
	logic [TEXEL_POS_W-1:0] x_c, y_c;
	logic [LIM_W-1:0]       width_lim, height_lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			texture_format_q <= FMT_DXT1;
			image_width_q    <= DIM_RESET;
			image_height_q   <= DIM_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TEXTURE_FORMAT: texture_format_q <= fmt_t'(cfg_data[1:0]);
				REG_IMAGE_WIDTH:    image_width_q    <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT:   image_height_q   <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	bcd_palette u_palette (
		.clk            (clk),
		.arst_n         (arst_n),
		.texture_format (texture_format_q),
		.blocks         (blocks),
		.pal            (pal),
		.pal_valid      (pal_valid),
		.pal_ready      (pal_ready)
	);

	assign rdy_s5    = !v_s5 || texels.ready;
	assign s4_emit   = v_s4 && rdy_s5;
	assign s4_done   = s4_emit && (cnt_q == {TEXEL_CNT_W{1'b1}});
	assign pal_ready = !v_s4 || s4_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4  <= 1'b0;
			cnt_q <= '0;
			v_s5  <= 1'b0;
		end else begin
			if (pal_ready) v_s4 <= pal_valid;
			// wrap to zero on the last texel
			if (s4_emit) cnt_q <= cnt_q + 1'b1;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (pal_ready && pal_valid) pal_s4 <= pal;
	end

	assign width_lim = (LIM_W'(image_width_q) > LIM_W'(MAX_DIMENSION)) ?
		LIM_W'(MAX_DIMENSION) : LIM_W'(image_width_q);
	assign height_lim = (LIM_W'(image_height_q) > LIM_W'(MAX_DIMENSION)) ?
		LIM_W'(MAX_DIMENSION) : LIM_W'(image_height_q);

	always_comb begin
		ci    = pal_s4.sel[{cnt_q, 1'b0} +: 2];
		col_c = pal_s4.color[ci];
		nib   = pal_s4.alpha_half[{cnt_q, 2'b00} +: 4];
		apos  = 6'd16 + {1'b0, cnt_q, 1'b0} + {2'b00, cnt_q};
		aidx  = pal_s4.alpha_half[apos +: 3];
		case (pal_s4.fmt)
			FMT_DXT1: alpha_c = col_c.a;
			FMT_DXT3: alpha_c = {nib, nib};
			default:  alpha_c = pal_s4.apal[aidx];
		endcase
		x_c = {pal_s4.block_col, cnt_q[1:0]};
		y_c = {pal_s4.block_row, cnt_q[3:2]};
	end

	always_ff @(posedge clk) begin
		if (s4_emit) begin
			texel_x_s5 <= x_c;
			texel_y_s5 <= y_c;
			rgba_s5    <= '{r: col_c.r, g: col_c.g, b: col_c.b, a: alpha_c};
			inside_s5  <= (LIM_W'(x_c) < width_lim) && (LIM_W'(y_c) < height_lim);
			last_s5    <= cnt_q == {TEXEL_CNT_W{1'b1}};
		end
	end

	assign texels.valid        = v_s5;
	assign texels.texel_x      = texel_x_s5;
	assign texels.texel_y      = texel_y_s5;
	assign texels.red          = rgba_s5.r;
	assign texels.green        = rgba_s5.g;
	assign texels.blue         = rgba_s5.b;
	assign texels.alpha        = rgba_s5.a;
	assign texels.inside_image = inside_s5;
	assign texels.last_texel   = last_s5;

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s4 |-> cnt_q == '0)
		else $error("serializer count nonzero with no block held");

	a_block_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !s4_done) |=> v_s4)
		else $error("block dropped before all texels were emitted");

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(texels.valid && texels.last_texel) |->
			(texels.texel_x[1:0] == 2'b11 && texels.texel_y[1:0] == 2'b11))
		else $error("last texel is not the bottom right corner of its block");

endmodule

FILE: verif/bcd_texel_checker.sv
// ----------------------------------------------------------------------------
// bcd_texel_checker: texel predictor and scoreboard for the block decoder
// Tracks the format and image size from the write port, decodes every block
// accepted on the block channel into its sixteen texels, and compares each
// texel accepted on the texel channel, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module bcd_texel_checker #(
	parameter int unsigned MAX_DIMENSION = bcd_pkg::DEFAULT_MAX_DIMENSION
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [bcd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bcd_pkg::CFG_DATA_W-1:0]  cfg_data,
	bcd_block_if                            blocks,
	bcd_texel_if                            texels,
	output int unsigned                     mismatches,
	output int unsigned                     texels_pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import bcd_pkg::*;

	typedef struct packed {
		logic [TEXEL_POS_W-1:0] texel_x;
		logic [TEXEL_POS_W-1:0] texel_y;
		chan_t                  red;
		chan_t                  green;
		chan_t                  blue;
		chan_t                  alpha;
		logic                   inside_image;
		logic                   last_texel;
	} texel_t;

	texel_t           expected_texels[$];
	logic [1:0]       cur_fmt;
	logic [DIM_W-1:0] cur_width;
	logic [DIM_W-1:0] cur_height;
	int unsigned      err_count = 0;

	function automatic void widen565(input logic [15:0] v, output int unsigned rgb[3]);
		int unsigned r5;
		int unsigned g6;
		int unsigned b5;
		r5 = v[15:11];
		g6 = v[10:5];
		b5 = v[4:0];
		rgb[0] = ((r5 << 3) | (r5 >> 2)) & 8'hFF;
		rgb[1] = ((g6 << 2) | (g6 >> 4)) & 8'hFF;
		rgb[2] = ((b5 << 3) | (b5 >> 2)) & 8'hFF;
	endfunction

	task automatic decode_block(input logic [ALPHA_HALF_W-1:0] ah,
		input logic [COLOR_HALF_W-1:0] ch, input logic [BLOCK_POS_W-1:0] col,
		input logic [BLOCK_POS_W-1:0] row);
		int unsigned e0[3];
		int unsigned e1[3];
		int unsigned pal[4][4];
		int unsigned apal[8];
		int unsigned c0, c1, a0, a1, w, h, x, y, ci, a;
		bit          four;
		texel_t      t;
		c0 = ch[15:0];
		c1 = ch[31:16];
		widen565(ch[15:0], e0);
		widen565(ch[31:16], e1);
		// only DXT1 with color0 <= color1 gets the transparent palette
		four = (cur_fmt != FMT_DXT1) || (c0 > c1);
		for (int k = 0; k < 3; k++) begin
			pal[0][k] = e0[k];
			pal[1][k] = e1[k];
			if (four) begin
				pal[2][k] = (2 * e0[k] + e1[k]) / 3;
				pal[3][k] = (e0[k] + 2 * e1[k]) / 3;
			end else begin
				pal[2][k] = (e0[k] + e1[k]) / 2;
				pal[3][k] = 0;
			end
		end
		pal[0][3] = 255;
		pal[1][3] = 255;
		pal[2][3] = 255;
		pal[3][3] = four ? 255 : 0;

		a0 = ah[7:0];
		a1 = ah[15:8];
		apal[0] = a0;
		apal[1] = a1;
		if (a0 > a1) begin
			for (int i = 1; i <= 6; i++)
				apal[i + 1] = ((7 - i) * a0 + i * a1) / 7;
		end else begin
			for (int i = 1; i <= 4; i++)
				apal[i + 1] = ((5 - i) * a0 + i * a1) / 5;
			apal[6] = 0;
			apal[7] = 255;
		end

		w = (cur_width > MAX_DIMENSION) ? MAX_DIMENSION : cur_width;
		h = (cur_height > MAX_DIMENSION) ? MAX_DIMENSION : cur_height;

		for (int p = 0; p < 16; p++) begin
			ci = ch[32 + 2 * p +: 2];
			x = col * 4 + (p % 4);
			y = row * 4 + (p / 4);
			// code 3 falls through to DXT5
			case (cur_fmt)
				FMT_DXT1: a = pal[ci][3];
				FMT_DXT3: a = ah[4 * p +: 4] * 17;
				default:  a = apal[ah[16 + 3 * p +: 3]];
			endcase
			t.texel_x      = x[TEXEL_POS_W-1:0];
			t.texel_y      = y[TEXEL_POS_W-1:0];
			t.red          = pal[ci][0][7:0];
			t.green        = pal[ci][1][7:0];
			t.blue         = pal[ci][2][7:0];
			t.alpha        = a[7:0];
			t.inside_image = (x < w) && (y < h);
			t.last_texel   = (p == 15);
			expected_texels.push_back(t);
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			err_count++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		texel_t want;
		if (!arst_n) begin
			expected_texels.delete();
			cur_fmt        = FMT_DXT1;
			cur_width      = DIM_RESET;
			cur_height     = DIM_RESET;
			texels_pending <= 0;
			mismatches     <= err_count;
		end else begin
			// check the outgoing texel before this edge's block is added
			if (texels.valid && texels.ready) begin
				if (expected_texels.size() == 0) begin
					err_count++;
					$error("texel at (%0d,%0d) with no block waiting",
						texels.texel_x, texels.texel_y);
				end else begin
					want = expected_texels.pop_front();
					compare_field("texel_x", want.texel_x, texels.texel_x);
					compare_field("texel_y", want.texel_y, texels.texel_y);
					compare_field("red", want.red, texels.red);
					compare_field("green", want.green, texels.green);
					compare_field("blue", want.blue, texels.blue);
					compare_field("alpha", want.alpha, texels.alpha);
					compare_field("inside_image", want.inside_image, texels.inside_image);
					compare_field("last_texel", want.last_texel, texels.last_texel);
				end
			end
			if (blocks.valid && blocks.ready)
				decode_block(blocks.alpha_half, blocks.color_half, blocks.block_col,
					blocks.block_row);
			if (cfg_write) begin
				case (cfg_index)
					REG_TEXTURE_FORMAT: cur_fmt    = cfg_data[1:0];
					REG_IMAGE_WIDTH:    cur_width  = cfg_data;
					REG_IMAGE_HEIGHT:   cur_height = cfg_data;
					default: ;
				endcase
			end
			texels_pending <= expected_texels.size();
			mismatches     <= err_count;
		end
	end

endmodule

FILE: verif/tb_bc1_bc2_bc3_block_decoder.sv
// ----------------------------------------------------------------------------
// tb_bc1_bc2_bc3_block_decoder: top level of the block decoder testbench
// Resets the decoder, walks it through DXT1, DXT3, DXT5 and the spare format
// code with edge-case image sizes, then random phases of random blocks with
// idling on both channels and one long texel back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_bc1_bc2_bc3_block_decoder;
	timeunit 1ns;
	timeprecision 1ps;
	import bcd_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 500000;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned RANDOM_PHASES = 10;
	localparam int unsigned PHASE_BLOCKS  = 40;
	localparam int unsigned TAIL_CYCLES   = 20;
	localparam int unsigned IDLE_PCT      = 21;

	// spare format code, decoded like DXT5
	localparam logic [1:0]  FMT_SPARE = 2'd3;
	// color selectors 0,1,2,3 repeated
	localparam logic [31:0] SEL_ALL   = 32'hE4E4E4E4;
	// alpha selectors 0..7 twice
	localparam logic [47:0] AIDX_ALL  = 48'hFAC688FAC688;

	typedef enum logic [1:0] {
		SINK_RANDOM,
		SINK_CALM,
		SINK_HOLD
	} sink_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int unsigned            mismatches;
	int unsigned            texels_pending;
	int unsigned            cycle_count = 0;
	int unsigned            hold_count = 0;
	bit                     src_calm = 1'b0;
	sink_mode_t             sink_mode = SINK_RANDOM;

	bcd_block_if blocks_if();
	bcd_texel_if texels_if();

	bc1_bc2_bc3_block_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.blocks    (blocks_if),
		.texels    (texels_if)
	);

	bcd_texel_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.blocks         (blocks_if),
		.texels         (texels_if),
		.mismatches     (mismatches),
		.texels_pending (texels_pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// texel sink: random idling, a calm stretch, and one long hold-off
	initial begin
		texels_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			case (sink_mode)
				SINK_HOLD: begin
					texels_if.ready <= 1'b0;
					hold_count++;
					if (hold_count == HOLD_CYCLES) begin
						hold_count = 0;
						sink_mode  = SINK_RANDOM;
					end
				end
				SINK_CALM: texels_if.ready <= 1'b1;
				default:   texels_if.ready <= ($urandom_range(99) >= IDLE_PCT);
			endcase
		end
	end

	task automatic send_block(input logic [ALPHA_HALF_W-1:0] ah,
		input logic [COLOR_HALF_W-1:0] ch, input logic [BLOCK_POS_W-1:0] col,
		input logic [BLOCK_POS_W-1:0] row);
		while (!src_calm && $urandom_range(99) < IDLE_PCT) begin
			blocks_if.valid <= 1'b0;
			@(posedge clk);
		end
		blocks_if.valid      <= 1'b1;
		blocks_if.alpha_half <= ah;
		blocks_if.color_half <= ch;
		blocks_if.block_col  <= col;
		blocks_if.block_row  <= row;
		do @(posedge clk); while (!blocks_if.ready);
	endtask

	// drop valid and wait until every texel of the phase is out
	task automatic drain_texels();
		blocks_if.valid <= 1'b0;
		do @(posedge clk); while (texels_pending != 0);
	endtask

	task automatic write_config(input logic [1:0] fmt, input logic [DIM_W-1:0] w,
		input logic [DIM_W-1:0] h);
		cfg_write <= 1'b1;
		cfg_index <= REG_TEXTURE_FORMAT;
		cfg_data  <= CFG_DATA_W'(fmt);
		@(posedge clk);
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(5))
			0:       return '0;
			1:       return DIM_W'($urandom_range(1, 16));
			2:       return DIM_RESET;
			3:       return DIM_W'($urandom_range(8193, 16383));
			default: return DIM_W'($urandom_range(1, 8192));
		endcase
	endfunction

	// half the blocks land on the image border to exercise the inside flag
	function automatic logic [BLOCK_POS_W-1:0] pick_pos(input int unsigned dim);
		int unsigned rim;
		if ($urandom_range(1) == 0)
			return BLOCK_POS_W'($urandom);
		rim = ((dim > DEFAULT_MAX_DIMENSION) ? DEFAULT_MAX_DIMENSION : dim) / 4;
		rim = rim + $urandom_range(2);
		rim = (rim >= 1) ? rim - 1 : 0;
		if (rim > 2047)
			rim = 2047;
		return rim[BLOCK_POS_W-1:0];
	endfunction

	task automatic send_random_block(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		logic [ALPHA_HALF_W-1:0] ah;
		logic [COLOR_HALF_W-1:0] ch;
		ah = {$urandom, $urandom};
		ch = {$urandom, $urandom};
		if ($urandom_range(7) == 0)
			ah[15:8] = ah[7:0];
		if ($urandom_range(7) == 0)
			ch[31:16] = ch[15:0];
		send_block(ah, ch, pick_pos(w), pick_pos(h));
	endtask

	initial begin
		logic [1:0]       fmt;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		arst_n               <= 1'b0;
		cfg_write            <= 1'b0;
		cfg_index            <= REG_TEXTURE_FORMAT;
		cfg_data             <= '0;
		blocks_if.valid      <= 1'b0;
		blocks_if.alpha_half <= '0;
		blocks_if.color_half <= '0;
		blocks_if.block_col  <= '0;
		blocks_if.block_row  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: DXT1, full-size image
		send_block('0, '0, '0, '0);
		send_block('1, '1, 11'd2047, 11'd2047);
		send_block('0, {SEL_ALL, 16'h0000, 16'hFFFF}, 11'd0, 11'd2047);
		send_block('1, {SEL_ALL, 16'hFFFF, 16'h0000}, 11'd2047, 11'd0);
		send_block('0, {SEL_ALL, 16'h7BEF, 16'h7BEF}, 11'd5, 11'd9);
		send_block('0, {SEL_ALL, 16'h001F, 16'hF81F}, 11'd1, 11'd1);
		drain_texels();

		// DXT3, width saturates, zero height leaves nothing inside
		write_config(FMT_DXT3, 14'h3FFF, 14'd0);
		send_block(64'hFEDCBA9876543210, {SEL_ALL, 16'hFFFF, 16'h0000}, 11'd0, 11'd0);
		send_block('0, '1, 11'd2047, 11'd0);
		send_block('1, {SEL_ALL, 16'h1234, 16'h8765}, 11'd3, 11'd0);
		drain_texels();

		// DXT5, one-texel image
		write_config(FMT_DXT5, 14'd1, 14'd1);
		send_block({AIDX_ALL, 8'h00, 8'hFF}, {SEL_ALL, 16'h0000, 16'hFFFF}, 11'd0, 11'd0);
		send_block({AIDX_ALL, 8'hFF, 8'h00}, {SEL_ALL, 16'hFFFF, 16'h0000}, 11'd0, 11'd0);
		send_block({AIDX_ALL, 8'h80, 8'h80}, {SEL_ALL, 16'h8410, 16'h8410}, 11'd1, 11'd0);
		send_block({AIDX_ALL, 8'h10, 8'hE0}, '1, 11'd0, 11'd1);
		drain_texels();

		// spare code, image edges cut through a block
		write_config(FMT_SPARE, 14'd6, 14'd5);
		send_block({AIDX_ALL, 8'h20, 8'hC0}, {SEL_ALL, 16'hF800, 16'h07E0}, 11'd1, 11'd1);
		send_block({AIDX_ALL, 8'hC0, 8'h20}, {SEL_ALL, 16'h07E0, 16'hF800}, 11'd0, 11'd0);
		send_block('1, '0, 11'd1, 11'd0);
		drain_texels();

		// DXT1 at the far corner, height saturates
		write_config(FMT_DXT1, 14'd8191, 14'd8193);
		send_block('0, {SEL_ALL, 16'h0000, 16'hFFFF}, 11'd2047, 11'd2047);
		send_block('0, {SEL_ALL, 16'hFFFF, 16'h0000}, 11'd2047, 11'd2046);
		send_block('1, {32'hFFFFFFFF, 16'hFFFF, 16'h0000}, 11'd2046, 11'd2047);
		drain_texels();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			fmt = 2'($urandom_range(3));
			w   = pick_dim();
			h   = pick_dim();
			write_config(fmt, w, h);
			src_calm = (ph == 6);
			if (ph == 3)
				sink_mode = SINK_HOLD;
			else if (ph == 6)
				sink_mode = SINK_CALM;
			else if (sink_mode == SINK_CALM)
				sink_mode = SINK_RANDOM;
			repeat (PHASE_BLOCKS) send_random_block(w, h);
			drain_texels();
		end

		// catch any stray texel after the last expected one
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
